// ===== src/vgsg_pkg.sv =====
// ----------------------------------------------------------------------------
// vgsg_pkg
// Types, constants, glyph ROM contents and starburst tables shared by the
// vector glyph stroke generator.
// ----------------------------------------------------------------------------
package vgsg_pkg;

  // Field widths
  localparam int CoordW   = 16;
  localparam int CodeW    = 8;
  localparam int ScaleW   = 7;
  localparam int StarW    = 3;
  localparam int NibW     = 4;

  // Glyph store geometry
  localparam int GlyphCount    = 64;
  localparam int GlyphAddrW    = $clog2(GlyphCount);
  localparam int StoredNibbles = 12;
  localparam int RowBits       = StoredNibbles * NibW;
  // Walk position reaches two past the number of stored nibbles
  localparam int PosW          = $clog2(StoredNibbles + 3);

  // Parameter defaults
  localparam int DefGlyphNibbles = 12;
  localparam int DefCoordBits    = 16;

  // Codes
  localparam logic [NibW-1:0]  NibTerm    = 4'hF;
  localparam logic [CodeW-1:0] CodeFirst  = 8'd33;
  localparam logic [CodeW-1:0] CodeLast   = 8'd96;
  localparam logic [CodeW-1:0] CharLowA   = 8'h61;
  localparam logic [CodeW-1:0] CharLowZ   = 8'h7A;
  localparam logic [CodeW-1:0] CaseOffset = 8'h20;

  // Configuration registers
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = ScaleW;
  localparam logic [CfgIdxW-1:0] CfgScaleX = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgScaleY = 1'b1;
  localparam logic [ScaleW-1:0]  ScaleReset = 7'd1;

  typedef struct packed {
    logic [CodeW-1:0]         char_code;
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x_start;
    logic signed [CoordW-1:0] y_start;
    logic signed [CoordW-1:0] x_end;
    logic signed [CoordW-1:0] y_end;
    logic                     last_segment;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [CoordW-1:0] origin_x;
    logic [CoordW-1:0] origin_y;
  } start_t;

  // One glyph per row, first vertex nibble in the top bits
  function automatic logic [RowBits-1:0] glyph_row(input logic [GlyphAddrW-1:0] g);
    logic [RowBits-1:0] r;
    case (g)
      6'd0:  r = 48'h05F8AF_FFFFFF;
      6'd1:  r = 48'h1EF24F_FFFFFF;
      6'd3:  r = 48'h4139B8_BFFFFF;
      6'd6:  r = 48'h1EFFFF_FFFFFF;
      6'd7:  r = 48'h2EDCFF_FFFFFF;
      6'd8:  r = 48'h0EDAFF_FFFFFF;
      6'd9:  r = 48'h0CF2AF_57FFFF;
      6'd10: r = 48'h57FEDF_FFFFFF;
      6'd11: r = 48'hDAFFFF_FFFFFF;
      6'd12: r = 48'h57FFFF_FFFFFF;
      6'd13: r = 48'h8AFFFF_FFFFFF;
      6'd14: r = 48'h2AFFFF_FFFFFF;
      6'd15: r = 48'h83149B_8FFFFF;
      6'd16: r = 48'h31BFAC_FFFFFF;
      6'd17: r = 48'h31478A_CFFFFF;
      6'd18: r = 48'h0149BA_F57FFF;
      6'd19: r = 48'hB65167_FFFFFF;
      6'd20: r = 48'h20569B_AFFFFF;
      6'd21: r = 48'h2158B9_75FFFF;
      6'd22: r = 48'h02AFFF_FFFFFF;
      6'd23: r = 48'h631469_B86FFF;
      6'd24: r = 48'h8B9413_5D7FFF;
      6'd25: r = 48'h1EFDBF_FFFFFF;
      6'd26: r = 48'h1EFDAF_FFFFFF;
      6'd27: r = 48'h25CFFF_FFFFFF;
      6'd28: r = 48'h57F89F_FFFFFF;
      6'd29: r = 48'h07AFFF_FFFFFF;
      6'd30: r = 48'hBD7413_FFFFFF;
      6'd31: r = 48'h9B8314_7D5ED5;
      6'd32: r = 48'hA517CF_57FFFF;
      6'd33: r = 48'hA01469_BA0F56;
      6'd34: r = 48'h4138B9_FFFFFF;
      6'd35: r = 48'h0AB941_0FFFFF;
      6'd36: r = 48'h20ACF5_6FFFFF;
      6'd37: r = 48'h20AF56_FFFFFF;
      6'd38: r = 48'h4138B9_76FFFF;
      6'd39: r = 48'h0AF2CF_75FFFF;
      6'd40: r = 48'h02FACF_1BFFFF;
      6'd41: r = 48'h29B8FF_FFFFFF;
      6'd42: r = 48'h0AF25C_FFFFFF;
      6'd43: r = 48'h0ACFFF_FFFFFF;
      6'd44: r = 48'hA0E2CF_FFFFFF;
      6'd45: r = 48'hA0C2FF_FFFFFF;
      6'd46: r = 48'h3149B8_3FFFFF;
      6'd47: r = 48'hA01465_FFFFFF;
      6'd48: r = 48'hDCF831_49B8FF;
      6'd49: r = 48'hA01465_CFFFFF;
      6'd50: r = 48'h4139B8_FFFFFF;
      6'd51: r = 48'h02F1BF_FFFFFF;
      6'd52: r = 48'h08B92F_FFFFFF;
      6'd53: r = 48'h0B2FFF_FFFFFF;
      6'd54: r = 48'h0A6C2F_FFFFFF;
      6'd55: r = 48'h0CF2AF_FFFFFF;
      6'd56: r = 48'h0E2BFF_FFFFFF;
      6'd57: r = 48'h02ACFF_FFFFFF;
      6'd58: r = 48'h21BCFF_FFFFFF;
      6'd59: r = 48'h0CFFFF_FFFFFF;
      6'd60: r = 48'h01BAFF_FFFFFF;
      6'd61: r = 48'h517FFF_FFFFFF;
      6'd62: r = 48'hACFFFF_FFFFFF;
      6'd63: r = 48'h0EFFFF_FFFFFF;
      default: r = 48'hFFFFFF_FFFFFF;
    endcase
    return r;
  endfunction

  // Starburst x position of a vertex
  function automatic logic [StarW-1:0] star_x(input logic [NibW-1:0] v);
    logic [StarW-1:0] s;
    case (v)
      4'd1, 4'd6, 4'd11, 4'd13, 4'd14: s = 3'd2;
      4'd2, 4'd4, 4'd7, 4'd9, 4'd12:   s = 3'd4;
      default:                         s = 3'd0;
    endcase
    return s;
  endfunction

  // Starburst y position of a vertex
  function automatic logic [StarW-1:0] star_y(input logic [NibW-1:0] v);
    logic [StarW-1:0] s;
    case (v)
      4'd3, 4'd4:          s = 3'd1;
      4'd5, 4'd6, 4'd7:    s = 3'd3;
      4'd8, 4'd9:          s = 3'd5;
      4'd10, 4'd11, 4'd12: s = 3'd6;
      4'd13:               s = 3'd4;
      4'd14:               s = 3'd2;
      default:             s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== src/vgsg_ram.sv =====
// ----------------------------------------------------------------------------
// vgsg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vgsg_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/vgsg_stroke.sv =====
// ----------------------------------------------------------------------------
// vgsg_stroke
// Walks the vertex nibbles of one glyph row, maps each vertex to screen
// coordinates and emits chained segments through an output register.
// ----------------------------------------------------------------------------
module vgsg_stroke #(
  parameter int GLYPH_NIBBLES = vgsg_pkg::DefGlyphNibbles,
  parameter int COORD_BITS    = vgsg_pkg::DefCoordBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  vgsg_pkg::start_t                 start_i,
  input  logic [vgsg_pkg::RowBits-1:0]     row_i,
  input  logic [vgsg_pkg::ScaleW-1:0]      scale_x_i,
  input  logic [vgsg_pkg::ScaleW-1:0]      scale_y_i,
  output logic                             busy_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output vgsg_pkg::out_item_t              out_item_o
);

  localparam int CoordW  = vgsg_pkg::CoordW;
  localparam int PosW    = vgsg_pkg::PosW;
  localparam int NibW    = vgsg_pkg::NibW;
  localparam int ProdW   = vgsg_pkg::StarW + vgsg_pkg::ScaleW;
  localparam int Limit   = (GLYPH_NIBBLES < vgsg_pkg::StoredNibbles) ?
                           GLYPH_NIBBLES : vgsg_pkg::StoredNibbles;
  localparam int MaskBits = (COORD_BITS < CoordW) ? COORD_BITS : CoordW;
  localparam logic [CoordW-1:0] CoordMask = CoordW'((64'd1 << MaskBits) - 64'd1);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StFirst   = 3'd1;
  localparam logic [2:0] StNext    = 3'd2;
  localparam logic [2:0] StRestart = 3'd3;
  localparam logic [2:0] StNext2   = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [PosW-1:0]         pos_q, pos_d;
  logic [CoordW-1:0]       ox_q, oy_q;
  logic [CoordW-1:0]       p1x_q, p1x_d, p1y_q, p1y_d;
  logic                    pend_q, pend_d;
  vgsg_pkg::out_item_t     seg_q, seg_d;
  logic                    out_valid_q, out_valid_d;
  vgsg_pkg::out_item_t     out_item_q, out_item_d;

  logic [NibW-1:0]         nibs [vgsg_pkg::StoredNibbles];
  logic [NibW-1:0]         cur_nib;
  logic                    is_term;
  logic [ProdW-1:0]        prod_x, prod_y;
  logic [CoordW-1:0]       pt_x, pt_y;
  logic                    step;
  logic                    push, push_last;

  always_comb begin
    for (int i = 0; i < vgsg_pkg::StoredNibbles; i++) begin
      nibs[i] = row_i[vgsg_pkg::RowBits-1-NibW*i -: NibW];
    end
  end

  // Positions past the glyph read as terminators
  assign is_term = (pos_q >= PosW'(Limit)) || (nibs[pos_q] == vgsg_pkg::NibTerm);
  assign cur_nib = is_term ? vgsg_pkg::NibTerm : nibs[pos_q];

  assign prod_x = ProdW'(vgsg_pkg::star_x(cur_nib)) * ProdW'(scale_x_i);
  assign prod_y = ProdW'(vgsg_pkg::star_y(cur_nib)) * ProdW'(scale_y_i);
  assign pt_x   = (ox_q + CoordW'(prod_x)) & CoordMask;
  assign pt_y   = (oy_q + CoordW'(prod_y)) & CoordMask;

  // Advance only when the output register can take a segment
  assign step = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    p1x_d     = p1x_q;
    p1y_d     = p1y_q;
    pend_d    = pend_q;
    seg_d     = seg_q;
    push      = 1'b0;
    push_last = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i.start) begin
          state_d = StFirst;
          pos_d   = '0;
        end
      end
      StFirst, StNext, StRestart, StNext2: begin
        if (step) begin
          pos_d = pos_q + PosW'(1);
          if (is_term && state_q == StNext) begin
            state_d = StRestart;
          end else if (is_term) begin
            // End of glyph: flush the held segment as the last one
            push      = pend_q;
            push_last = 1'b1;
            pend_d    = 1'b0;
            state_d   = StIdle;
          end else if (state_q == StFirst || state_q == StRestart) begin
            p1x_d   = pt_x;
            p1y_d   = pt_y;
            state_d = (state_q == StFirst) ? StNext : StNext2;
          end else begin
            // New segment: release the held one, hold this one
            push   = pend_q;
            pend_d = 1'b1;
            seg_d  = '{x_start: p1x_q, y_start: p1y_q, x_end: pt_x, y_end: pt_y,
                       last_segment: 1'b0};
            p1x_d  = pt_x;
            p1y_d  = pt_y;
            state_d = StNext;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_item_d  = seg_q;
      out_item_d.last_segment = push_last;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pos_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i.start && state_q == StIdle) begin
      ox_q <= start_i.origin_x;
      oy_q <= start_i.origin_y;
    end
    p1x_q      <= p1x_d;
    p1y_q      <= p1y_d;
    seg_q      <= seg_d;
    out_item_q <= out_item_d;
  end

  assign busy_o      = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i.start |-> state_q == StIdle)
    else $error("glyph started while walker busy");

  a_idle_nothing_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> !pend_q)
    else $error("segment left held after glyph end");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_item_q)))
    else $error("stalled segment changed");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> pos_q <= PosW'(Limit + 2))
    else $error("walk position ran past the glyph");

endmodule

// ===== src/vector_glyph_stroke_generator.sv =====
// ----------------------------------------------------------------------------
// vector_glyph_stroke_generator
// Turns a character code and screen origin into the line segments of its
// vector glyph, read from an on-chip glyph memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_stall_o   | char_code, origin_x, origin_y
//  out     | output    | out_valid_o/out_stall_i | x/y start, x/y end, last_segment
//  cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
//  Each item first fetches its glyph row, then the stroke walker takes one vertex
//  nibble per cycle while the output is not stalled (up to 12 nibbles plus two
//  terminator reads).
//  Out-of-range codes and empty glyphs are taken and give nothing.
//  After reset the glyph memory is loaded; in_stall_o stays high while it loads.
//  A stall on the output holds the walker; the next item may enter while the
//  final segment still waits in the output register.
// ----------------------------------------------------------------------------
module vector_glyph_stroke_generator #(
  parameter int GLYPH_NIBBLES = vgsg_pkg::DefGlyphNibbles,
  parameter int COORD_BITS    = vgsg_pkg::DefCoordBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  vgsg_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output vgsg_pkg::out_item_t             out_item_o,
  input  logic                            cfg_we_i,
  input  logic [vgsg_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [vgsg_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int AddrW = vgsg_pkg::GlyphAddrW;

  logic [vgsg_pkg::ScaleW-1:0]   scale_x_q, scale_y_q;
  logic                          filling_q;
  logic [AddrW-1:0]              fill_q;
  logic [vgsg_pkg::CodeW-1:0]    code;
  logic                          in_range;
  logic                          in_acc;
  logic                          busy;
  vgsg_pkg::start_t              start;
  logic [vgsg_pkg::RowBits-1:0]  row;
  logic [vgsg_pkg::CodeW-1:0]    code_off;

  // Fold lowercase to uppercase
  always_comb begin
    code = in_item_i.char_code;
    if (code >= vgsg_pkg::CharLowA && code <= vgsg_pkg::CharLowZ) begin
      code = code - vgsg_pkg::CaseOffset;
    end
  end

  assign in_range   = (code >= vgsg_pkg::CodeFirst) && (code <= vgsg_pkg::CodeLast);
  assign code_off   = code - vgsg_pkg::CodeFirst;
  assign in_stall_o = filling_q || busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign start.start    = in_acc && in_range;
  assign start.origin_x = in_item_i.origin_x;
  assign start.origin_y = in_item_i.origin_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q <= vgsg_pkg::ScaleReset;
      scale_y_q <= vgsg_pkg::ScaleReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vgsg_pkg::CfgScaleX: scale_x_q <= cfg_data_i;
        vgsg_pkg::CfgScaleY: scale_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Load the glyph memory from the ROM image, one row a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filling_q <= 1'b1;
      fill_q    <= '0;
    end else if (filling_q) begin
      fill_q <= fill_q + AddrW'(1);
      if (fill_q == AddrW'(vgsg_pkg::GlyphCount - 1)) begin
        filling_q <= 1'b0;
      end
    end
  end

  vgsg_ram #(
    .Width (vgsg_pkg::RowBits),
    .Depth (vgsg_pkg::GlyphCount)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (filling_q),
    .waddr_i (fill_q),
    .wdata_i (vgsg_pkg::glyph_row(fill_q)),
    .re_i    (start.start),
    .raddr_i (code_off[AddrW-1:0]),
    .rdata_o (row)
  );

  vgsg_stroke #(
    .GLYPH_NIBBLES (GLYPH_NIBBLES),
    .COORD_BITS    (COORD_BITS)
  ) u_stroke (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .row_i       (row),
    .scale_x_i   (scale_x_q),
    .scale_y_i   (scale_y_q),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
